/* sv/erst_pkg.sv */
// ----------------------------------------------------------------------------
// erst_pkg
// Shared widths and types for the engine rpm tracker and its serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

package erst_pkg;

    // numerator 60 * ticks * multiplier stays below 2^40
    localparam int NUM_W = 40;
    localparam int DEN_W = 32;
    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef logic [NUM_W-1:0] num_t;
    typedef logic [DEN_W-1:0] den_t;

endpackage

`default_nettype wire

/* sv/engine_rpm_state_tracker.sv */
// ----------------------------------------------------------------------------
// engine_rpm_state_tracker
// Rpm measurement from the sync period, spinning detection, engine state and
// revolution counters.
// ----------------------------------------------------------------------------
// One request is handled at a time. A non-sync tooth goes straight to output,
// a stop request through apply, a sync tooth through measure, check and apply;
// one finding the engine spinning with a non-zero period also runs the
// bit-serial divider, which produces one of the 40 quotient bits per clock.
// The result sits in an output register, so a new request is taken while the
// last result still waits; a result is held back only while the one before it
// is still unread. The user writes configuration through the plain write port
// only when the block is idle; the block itself does not enforce this.
`default_nettype none

module engine_rpm_state_tracker #(
    parameter int TIMEOUT_SECONDS = 2
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,

    input  wire logic          cfg_wr_en,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_wr_data,

    input  wire logic          s_tvalid,
    output logic               s_tready,
    // [31:0] event_time, [63:32] previous_tooth_time, [64] stop_requested
    input  wire logic [71:0]   s_tdata,
    // [0] action, [1] sync_point
    input  wire logic [1:0]    s_tuser,

    output logic               m_tvalid,
    input  wire logic          m_tready,
    // [16:0] rpm_value, [18:17] engine_state, [35:19] previous_rpm,
    // [67:36] revs_since_start, [99:68] revs_since_boot
    output logic [103:0]       m_tdata
);

    localparam int TMO_W     = erst_pkg::DEN_W + $clog2(TIMEOUT_SECONDS + 1);
    localparam int RPM_SCALE = 60;

    localparam logic [1:0] REG_TPS    = 2'd0;
    localparam logic [1:0] REG_CRANK  = 2'd1;
    localparam logic [1:0] REG_MULT   = 2'd2;
    localparam logic [1:0] REG_UNREAL = 2'd3;

    localparam logic [1:0] MODE_STOPPED  = 2'd0;
    localparam logic [1:0] MODE_CRANKING = 2'd1;
    localparam logic [1:0] MODE_RUNNING  = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_NOISY = 2'd1;
    localparam logic [1:0] KIND_QUOT  = 2'd2;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MEASURE = 3'd1;
    localparam logic [2:0] ST_CHECK   = 3'd2;
    localparam logic [2:0] ST_DIV     = 3'd3;
    localparam logic [2:0] ST_APPLY   = 3'd4;
    localparam logic [2:0] ST_OUT     = 3'd5;

    localparam logic [16:0] RPM_NOISY = 17'h1FFFF;

    // configuration
    logic [31:0] tps_reg;
    logic [15:0] crank_lim_reg;
    logic [1:0]  mult_reg;
    logic [15:0] unreal_lim_reg;

    // engine state
    logic [31:0] last_sync_reg;
    logic        sync_seen_reg;
    logic [16:0] cur_rpm_reg;
    logic [16:0] prior_rpm_reg;
    logic [1:0]  mode_reg;
    logic [31:0] start_revs_reg;
    logic [31:0] boot_revs_reg;

    // request and working registers
    logic [2:0]  state_reg;
    logic        action_reg;
    logic        sync_reg;
    logic        stop_reg;
    logic [31:0] now_reg;
    logic [31:0] prev_tooth_reg;
    logic [31:0] since_sync_reg;
    logic [31:0] since_tooth_reg;
    logic [TMO_W-1:0] tmo_lim_reg;
    erst_pkg::num_t   num_reg;
    logic [1:0]  kind_reg;
    logic [15:0] q16_reg;

    logic        m_tvalid_reg;
    logic [103:0] out_data_reg;

    logic        div_start;
    logic        div_done;
    erst_pkg::num_t div_quo;

    logic [7:0]  scale;
    logic        spinning;
    logic        quo_noisy;
    logic        out_load;

    assign scale     = 8'(RPM_SCALE) * {6'd0, mult_reg};
    assign spinning  = !stop_reg && sync_seen_reg
                       && (TMO_W'(since_sync_reg) < tmo_lim_reg)
                       && (since_tooth_reg < tps_reg);
    assign quo_noisy = (|div_quo[erst_pkg::NUM_W-1:16]) || (div_quo[15:0] > unreal_lim_reg);
    assign div_start = (state_reg == ST_CHECK) && spinning && (since_sync_reg != '0);
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    erst_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .numerator (num_reg),
        .divisor   (since_sync_reg),
        .done      (div_done),
        .quotient  (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg        <= 32'd1000000;
            crank_lim_reg  <= 16'd550;
            mult_reg       <= 2'd2;
            unreal_lim_reg <= 16'd30000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TPS:    tps_reg        <= cfg_wr_data;
                REG_CRANK:  crank_lim_reg  <= cfg_wr_data[15:0];
                REG_MULT:   mult_reg       <= cfg_wr_data[1:0];
                REG_UNREAL: unreal_lim_reg <= cfg_wr_data[15:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            last_sync_reg  <= '0;
            sync_seen_reg  <= 1'b0;
            cur_rpm_reg    <= '0;
            prior_rpm_reg  <= '0;
            mode_reg       <= MODE_STOPPED;
            start_revs_reg <= '0;
            boot_revs_reg  <= '0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser[0]) begin
                            state_reg <= ST_APPLY;
                        end else if (s_tuser[1]) begin
                            state_reg <= ST_MEASURE;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_MEASURE: begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    state_reg <= div_start ? ST_DIV : ST_APPLY;
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    if (action_reg) begin
                        start_revs_reg <= '0;
                        if (cur_rpm_reg != '0) begin
                            prior_rpm_reg <= cur_rpm_reg;
                            cur_rpm_reg   <= '0;
                        end
                        mode_reg <= MODE_STOPPED;
                    end else begin
                        if (kind_reg != KIND_NONE) begin
                            prior_rpm_reg <= cur_rpm_reg;
                            cur_rpm_reg   <= (kind_reg == KIND_NOISY) ? RPM_NOISY
                                                                      : {1'b0, q16_reg};
                            if (kind_reg == KIND_QUOT && q16_reg == '0) begin
                                mode_reg <= MODE_STOPPED;
                            end else if (kind_reg == KIND_QUOT && q16_reg >= crank_lim_reg) begin
                                mode_reg <= MODE_RUNNING;
                            end else if (mode_reg == MODE_STOPPED) begin
                                mode_reg <= MODE_CRANKING;
                            end
                        end
                        boot_revs_reg  <= boot_revs_reg + 32'd1;
                        start_revs_reg <= start_revs_reg + 32'd1;
                        last_sync_reg  <= now_reg;
                        sync_seen_reg  <= 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            action_reg     <= s_tuser[0];
            sync_reg       <= s_tuser[1];
            now_reg        <= s_tdata[31:0];
            prev_tooth_reg <= s_tdata[63:32];
            stop_reg       <= s_tdata[64];
        end
        if (state_reg == ST_MEASURE) begin
            since_sync_reg  <= now_reg - last_sync_reg;
            since_tooth_reg <= now_reg - prev_tooth_reg;
            tmo_lim_reg     <= TMO_W'(tps_reg) * TMO_W'(TIMEOUT_SECONDS);
            num_reg         <= erst_pkg::NUM_W'(tps_reg) * erst_pkg::NUM_W'(scale);
        end
        if (state_reg == ST_CHECK) begin
            if (!spinning || !sync_reg) begin
                kind_reg <= KIND_NONE;
            end else if (since_sync_reg == '0) begin
                kind_reg <= KIND_NOISY;
            end else begin
                kind_reg <= KIND_QUOT;
            end
        end
        if (state_reg == ST_DIV && div_done) begin
            kind_reg <= quo_noisy ? KIND_NOISY : KIND_QUOT;
            q16_reg  <= div_quo[15:0];
        end
        if (out_load) begin
            out_data_reg <= {4'd0, boot_revs_reg, start_revs_reg, prior_rpm_reg,
                             mode_reg, cur_rpm_reg};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* sv/erst_divider.sv */
// ----------------------------------------------------------------------------
// erst_divider
// Bit-serial restoring divider: one quotient bit per clock, numerator shifted
// out of the top of the quotient register as quotient bits enter the bottom.
// ----------------------------------------------------------------------------
`default_nettype none

module erst_divider (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire erst_pkg::num_t  numerator,
    input  wire erst_pkg::den_t  divisor,
    output logic                 done,
    output erst_pkg::num_t       quotient
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [erst_pkg::CNT_W-1:0]  cnt_reg;
    erst_pkg::den_t              rem_reg;
    erst_pkg::den_t              den_reg;
    erst_pkg::num_t              quo_reg;

    logic [erst_pkg::DEN_W:0]    trial;
    logic [erst_pkg::DEN_W:0]    diff;
    logic                        fits;

    assign trial = {rem_reg, quo_reg[erst_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + erst_pkg::CNT_W'(1);
                if (cnt_reg == erst_pkg::CNT_W'(erst_pkg::NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= divisor;
            quo_reg <= numerator;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[erst_pkg::DEN_W-1:0] : trial[erst_pkg::DEN_W-1:0];
            quo_reg <= {quo_reg[erst_pkg::NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
